@@ rtl/core/fla_pkg.sv @@
// shared types, codes and constants of the framed link engine
package fla_pkg;

    // frame layout
    localparam int FRAME_LENGTH = 5;
    localparam int POS_W        = 3;
    localparam int FB_DEPTH     = 3;
    localparam logic [POS_W-1:0] POS_HUNT = 3'd0;

    // field widths
    localparam int BYTE_W = 8;
    localparam int WAIT_W = 20;
    localparam int CMD_W  = 2;
    localparam int KIND_W = 3;
    localparam int IDX_W  = 3;

    // default timer width
    localparam int TIMER_BITS_DEF = 20;

    // result run of one item
    localparam int RUN_MAX = 5;
    localparam int CNT_W   = 3;

    // input commands
    localparam logic [CMD_W-1:0] CMD_RX    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEND  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // event kinds
    localparam logic [KIND_W-1:0] EV_TX       = 3'd0;
    localparam logic [KIND_W-1:0] EV_CMD_RX   = 3'd1;
    localparam logic [KIND_W-1:0] EV_ACK_TO   = 3'd2;
    localparam logic [KIND_W-1:0] EV_CYCLE_TO = 3'd3;
    localparam logic [KIND_W-1:0] EV_VERSION  = 3'd4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_START_CODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_END_CODE      = 3'd1;
    localparam logic [IDX_W-1:0] REG_ACK_WAIT      = 3'd2;
    localparam logic [IDX_W-1:0] REG_CYCLE_WAIT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_DISP_START    = 3'd4;
    localparam logic [IDX_W-1:0] REG_DISP_DONE     = 3'd5;
    localparam logic [IDX_W-1:0] REG_VERSION_QUERY = 3'd6;

    // register reset values
    localparam logic [WAIT_W-1:0] ACK_WAIT_RST   = 20'd5000;
    localparam logic [WAIT_W-1:0] CYCLE_WAIT_RST = 20'd10000;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [WAIT_W-1:0] ack_wait_ticks;
        logic [WAIT_W-1:0] cycle_wait_ticks;
        logic [BYTE_W-1:0] dispense_start_code;
        logic [BYTE_W-1:0] dispense_done_code;
        logic [BYTE_W-1:0] version_query_code;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]                   cnt;
        logic [RUN_MAX-1:0][KIND_W-1:0]     kind;
        logic [RUN_MAX-1:0][BYTE_W-1:0]     value;
        logic [BYTE_W-1:0]                  product_kind;
        logic [BYTE_W-1:0]                  firmware_rev;
        logic [BYTE_W-1:0]                  cycle_total;
        logic                               version_valid;
    } t_run;

endpackage

@@ rtl/core/fla_cfg.sv @@
// configuration register file of the framed link engine
module fla_cfg
    import fla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [WAIT_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    // always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code          <= '0;
            r_cfg.end_code            <= '0;
            r_cfg.ack_wait_ticks      <= ACK_WAIT_RST;
            r_cfg.cycle_wait_ticks    <= CYCLE_WAIT_RST;
            r_cfg.dispense_start_code <= '0;
            r_cfg.dispense_done_code  <= '0;
            r_cfg.version_query_code  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_START_CODE:    r_cfg.start_code          <= i_cfg_data[BYTE_W-1:0];
                REG_END_CODE:      r_cfg.end_code            <= i_cfg_data[BYTE_W-1:0];
                REG_ACK_WAIT:      r_cfg.ack_wait_ticks      <= i_cfg_data;
                REG_CYCLE_WAIT:    r_cfg.cycle_wait_ticks    <= i_cfg_data;
                REG_DISP_START:    r_cfg.dispense_start_code <= i_cfg_data[BYTE_W-1:0];
                REG_DISP_DONE:     r_cfg.dispense_done_code  <= i_cfg_data[BYTE_W-1:0];
                REG_VERSION_QUERY: r_cfg.version_query_code  <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/fla_core.sv @@
// link state: receive framing, timers, version capture and result run build
module fla_core
    import fla_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [BYTE_W-1:0] i_rx_value,
    input  logic [BYTE_W-1:0] i_send_command,
    input  logic [BYTE_W-1:0] i_send_data,
    input  t_cfg              i_cfg,
    output t_run              o_run
);

    localparam int WIDE_W = (TIMER_BITS > WAIT_W) ? TIMER_BITS : WAIT_W;

    logic [POS_W-1:0]      r_pos,  n_pos;
    logic [BYTE_W-1:0]     r_fb [0:FB_DEPTH-1];
    logic [BYTE_W-1:0]     n_fb [0:FB_DEPTH-1];
    logic [TIMER_BITS-1:0] r_ack,  n_ack;
    logic [TIMER_BITS-1:0] r_cyc,  n_cyc;
    logic                  r_await, n_await;
    logic [BYTE_W-1:0]     r_vs [0:FB_DEPTH-1];
    logic [BYTE_W-1:0]     n_vs [0:FB_DEPTH-1];
    logic                  r_ok,   n_ok;

    logic [TIMER_BITS-1:0] ack_arm;
    logic [TIMER_BITS-1:0] cyc_arm;
    logic                  ack_exp;
    logic                  cyc_exp;
    t_run                  run;

    // arming value: zero arms for one tick, large waits saturate
    function automatic logic [TIMER_BITS-1:0] arm_value(input logic [WAIT_W-1:0] wait_ticks);
        logic [WIDE_W-1:0] wide_wait;
        logic [WIDE_W-1:0] wide_max;
        logic [TIMER_BITS-1:0] res;
        wide_wait = WIDE_W'(wait_ticks);
        wide_max  = WIDE_W'({TIMER_BITS{1'b1}});
        if (wide_wait == '0) begin
            res = TIMER_BITS'(1);
        end else if (wide_wait > wide_max) begin
            res = {TIMER_BITS{1'b1}};
        end else begin
            res = TIMER_BITS'(wide_wait);
        end
        return res;
    endfunction

    assign ack_arm = arm_value(i_cfg.ack_wait_ticks);
    assign cyc_arm = arm_value(i_cfg.cycle_wait_ticks);
    assign ack_exp = (r_ack == TIMER_BITS'(1));
    assign cyc_exp = (r_cyc == TIMER_BITS'(1));

    // next state and result run of the item at the input
    always_comb begin
        n_pos   = r_pos;
        n_ack   = r_ack;
        n_cyc   = r_cyc;
        n_await = r_await;
        n_ok    = r_ok;
        for (int i = 0; i < FB_DEPTH; i++) begin
            n_fb[i] = r_fb[i];
            n_vs[i] = r_vs[i];
        end
        run = '0;

        if (i_accept) begin
            case (i_cmd)
                CMD_RX: begin
                    case (r_pos)
                        POS_HUNT: begin
                            if (i_rx_value == i_cfg.start_code) begin
                                n_pos = 3'd1;
                            end
                        end
                        3'd1, 3'd2, 3'd3: begin
                            n_fb[2'(r_pos - 3'd1)] = i_rx_value;
                            n_pos = r_pos + 3'd1;
                        end
                        default: begin
                            // end byte: judge the frame
                            n_pos = POS_HUNT;
                            if (i_rx_value == i_cfg.end_code) begin
                                n_ack = '0;
                                if (r_fb[0] == i_cfg.dispense_done_code) begin
                                    n_cyc = '0;
                                end
                                if (r_fb[0] == i_cfg.version_query_code) begin
                                    n_await = 1'b1;
                                end else if (r_await) begin
                                    for (int i = 0; i < FB_DEPTH; i++) begin
                                        n_vs[i] = r_fb[i];
                                    end
                                    n_ok     = 1'b1;
                                    n_await  = 1'b0;
                                    run.cnt  = 3'd1;
                                    run.kind[0] = EV_VERSION;
                                end else begin
                                    run.cnt      = 3'd1;
                                    run.kind[0]  = EV_CMD_RX;
                                    run.value[0] = r_fb[0];
                                end
                            end
                        end
                    endcase
                end
                CMD_TICK: begin
                    if (r_ack != '0) begin
                        n_ack = r_ack - TIMER_BITS'(1);
                    end
                    if (r_cyc != '0) begin
                        n_cyc = r_cyc - TIMER_BITS'(1);
                    end
                    // ack timeout goes ahead of cycle timeout
                    if (ack_exp && cyc_exp) begin
                        run.cnt     = 3'd2;
                        run.kind[0] = EV_ACK_TO;
                        run.kind[1] = EV_CYCLE_TO;
                    end else if (ack_exp) begin
                        run.cnt     = 3'd1;
                        run.kind[0] = EV_ACK_TO;
                    end else if (cyc_exp) begin
                        run.cnt     = 3'd1;
                        run.kind[0] = EV_CYCLE_TO;
                    end
                end
                CMD_SEND: begin
                    n_pos = POS_HUNT;
                    n_ok  = 1'b0;
                    if (i_send_command == i_cfg.version_query_code) begin
                        n_await = 1'b0;
                    end
                    n_ack = ack_arm;
                    if (i_send_command == i_cfg.dispense_start_code) begin
                        n_cyc = cyc_arm;
                    end
                    run.cnt = CNT_W'(RUN_MAX);
                    for (int i = 0; i < RUN_MAX; i++) begin
                        run.kind[i] = EV_TX;
                    end
                    run.value[0] = i_cfg.start_code;
                    run.value[1] = i_send_command;
                    run.value[2] = i_send_data;
                    run.value[3] = i_send_command + i_send_data;
                    run.value[4] = i_cfg.end_code;
                end
                default: begin
                    // clear
                    n_ack   = '0;
                    n_cyc   = '0;
                    n_await = 1'b0;
                    n_ok    = 1'b0;
                    n_pos   = POS_HUNT;
                end
            endcase
        end

        // version fields as left by this item
        run.product_kind  = n_vs[0];
        run.firmware_rev  = n_vs[1];
        run.cycle_total   = n_vs[2];
        run.version_valid = n_ok;
    end

    assign o_run = run;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_HUNT;
            r_ack   <= '0;
            r_cyc   <= '0;
            r_await <= 1'b0;
            r_ok    <= 1'b0;
            for (int i = 0; i < FB_DEPTH; i++) begin
                r_vs[i] <= '0;
            end
        end else begin
            r_pos   <= n_pos;
            r_ack   <= n_ack;
            r_cyc   <= n_cyc;
            r_await <= n_await;
            r_ok    <= n_ok;
            for (int i = 0; i < FB_DEPTH; i++) begin
                r_vs[i] <= n_vs[i];
            end
        end
    end

    // collected frame bytes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FB_DEPTH; i++) begin
            r_fb[i] <= n_fb[i];
        end
    end

endmodule

@@ rtl/core/fla_out.sv @@
// result register: holds one item's run and hands it out a beat at a time
module fla_out
    import fla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_run              i_run,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_event_kind,
    output logic [BYTE_W-1:0] o_event_value,
    output logic              o_last_of_run,
    output logic [BYTE_W-1:0] o_product_kind,
    output logic [BYTE_W-1:0] o_firmware_rev,
    output logic [BYTE_W-1:0] o_cycle_total,
    output logic              o_version_valid
);

    logic [CNT_W-1:0]               r_cnt;
    logic [RUN_MAX-1:0][KIND_W-1:0] r_kind;
    logic [RUN_MAX-1:0][BYTE_W-1:0] r_value;
    logic [BYTE_W-1:0]              r_pk;
    logic [BYTE_W-1:0]              r_fw;
    logic [BYTE_W-1:0]              r_ct;
    logic                           r_vv;
    logic                           take;

    assign take   = o_valid && !i_stall;
    // room for a new run when empty or the last beat leaves now
    assign o_free = (r_cnt == '0) || (r_cnt == CNT_W'(1) && take);

    assign o_valid         = (r_cnt != '0);
    assign o_event_kind    = r_kind[0];
    assign o_event_value   = r_value[0];
    assign o_last_of_run   = (r_cnt == CNT_W'(1));
    assign o_product_kind  = r_pk;
    assign o_firmware_rev  = r_fw;
    assign o_cycle_total   = r_ct;
    assign o_version_valid = r_vv;

    // beat count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_run.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // run payload, shifted down as beats leave
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind  <= i_run.kind;
            r_value <= i_run.value;
            r_pk    <= i_run.product_kind;
            r_fw    <= i_run.firmware_rev;
            r_ct    <= i_run.cycle_total;
            r_vv    <= i_run.version_valid;
        end else if (take) begin
            for (int i = 0; i < RUN_MAX - 1; i++) begin
                r_kind[i]  <= r_kind[i+1];
                r_value[i] <= r_value[i+1];
            end
        end
    end

endmodule

@@ rtl/core/framed_link_with_ack_timeout_top.sv @@
// top level of the framed link engine with acknowledge and cycle timers
// At most one input beat is taken per cycle. Each beat is handled in the cycle it is
// accepted and its results (none, one, two timeouts, or a sent frame's five bytes) land
// in a result register. A new input beat is taken once that register is empty or its last
// beat is taken. Unless stalled, the register puts out one beat per cycle, items with at
// most one result run at one per cycle and a send holds the input for five output beats.
// Configuration writes are always ready and should only be made while the block is idle.
module framed_link_with_ack_timeout_top
    import fla_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input beats
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [BYTE_W-1:0] i_rx_value,
    input  logic [BYTE_W-1:0] i_send_command,
    input  logic [BYTE_W-1:0] i_send_data,
    // result beats
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_event_kind,
    output logic [BYTE_W-1:0] o_event_value,
    output logic              o_last_of_run,
    output logic [BYTE_W-1:0] o_product_kind,
    output logic [BYTE_W-1:0] o_firmware_rev,
    output logic [BYTE_W-1:0] o_cycle_total,
    output logic              o_version_valid,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [WAIT_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_run run;
    logic free;
    logic accept;

    assign o_stall = !free;
    assign accept  = i_valid && free;

    // configuration registers
    fla_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // link state and run build
    fla_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_cmd          (i_cmd),
        .i_rx_value     (i_rx_value),
        .i_send_command (i_send_command),
        .i_send_data    (i_send_data),
        .i_cfg          (cfg),
        .o_run          (run)
    );

    // result register
    fla_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept),
        .i_run           (run),
        .o_free          (free),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_event_value   (o_event_value),
        .o_last_of_run   (o_last_of_run),
        .o_product_kind  (o_product_kind),
        .o_firmware_rev  (o_firmware_rev),
        .o_cycle_total   (o_cycle_total),
        .o_version_valid (o_version_valid)
    );

endmodule
